>>> sv/mspd_pkg.sv
// Package for motor_speed_pid_drive: field widths, register indexes, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mspd_pkg;
    localparam int MulW  = 33;          // signed operand width of the shared multiplier
    localparam int ProdW = 2 * MulW;
    localparam int DivNW = 58;          // dividend / quotient width
    localparam int DivDW = 32;          // divisor width

    localparam logic [29:0] NsPerS  = 30'd1000000000;
    localparam logic [19:0] UsPerS  = 20'd1000000;
    localparam logic [15:0] TpmRst  = 16'd1000;

    typedef enum logic [2:0] {
        REG_MODE = 3'd0,
        REG_GP   = 3'd1,
        REG_GI   = 3'd2,
        REG_GD   = 3'd3,
        REG_TPM  = 3'd4,
        REG_OFF  = 3'd5,
        REG_SLP  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // saturate a product to +-2^40
    function automatic logic signed [41:0] sat_term(input logic signed [ProdW-1:0] v);
        logic signed [ProdW-1:0] lim;
        lim = ProdW'(64'sd1 <<< 40);
        if (v > lim)       sat_term = 42'sd1 <<< 40;
        else if (v < -lim) sat_term = -(42'sd1 <<< 40);
        else               sat_term = v[41:0];
    endfunction
endpackage
`default_nettype wire

>>> sv/mspd_mul.sv
// Shared signed multiplier with registered product.
// Depends on mspd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mspd_mul (
    input  wire logic                              i_clk,
    input  wire logic signed [mspd_pkg::MulW-1:0]  i_a,
    input  wire logic signed [mspd_pkg::MulW-1:0]  i_b,
    output logic signed [mspd_pkg::ProdW-1:0]      o_prod
);
    logic signed [mspd_pkg::ProdW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

>>> sv/mspd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mspd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mspd_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mspd_pkg::DivNW-1:0]    i_num,
    input  wire logic [mspd_pkg::DivDW-1:0]    i_den,
    output logic [mspd_pkg::DivNW-1:0]         o_quo,
    output mspd_pkg::t_div_stat                o_stat
);
    localparam int CntW = $clog2(mspd_pkg::DivNW);

    logic [mspd_pkg::DivDW-1:0] r_rem, r_den;
    logic [mspd_pkg::DivNW-1:0] r_quo;
    logic [CntW-1:0]            r_cnt;
    logic                       r_busy, r_done;
    logic [mspd_pkg::DivDW:0]   rem_sh, rem_sub;
    logic                       q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_quo[mspd_pkg::DivNW-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(mspd_pkg::DivNW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[mspd_pkg::DivDW-1:0] : rem_sh[mspd_pkg::DivDW-1:0];
            r_quo <= {r_quo[mspd_pkg::DivNW-2:0], q_bit};
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule
`default_nettype wire

>>> sv/motor_speed_pid_drive.sv
// Channel   Dir  Width  Contents
// s (in)    in   48     encoder_count, elapsed_us, target_speed
// m (out)   out  32     duty, drive_a, drive_b, measured_speed
// cfg       in   32     write enable, 3-bit register index, data
//
// One item at a time: input is taken again only after the previous item's result has
// entered the output register, in PID mode and in feedforward mode alike.
// The sequence runs through the shared bit-serial divider (58 quotient steps per
// division, one for speed, one more for the derivative term in PID mode) and the
// shared multiplier.
// Reset is synchronous; it resets the sequencer, persistent state and config registers.
// A stalled result waits in the output register; input is taken again once it frees.
// Depends on mspd_pkg, mspd_mul, mspd_div.
`timescale 1ns / 1ps
`default_nettype none
module motor_speed_pid_drive (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // encoder_count, elapsed_us, target_speed
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // duty, drive_a, drive_b, measured_speed, pad
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data
);
    typedef enum logic [16:0] {
        S_IDLE = 17'h00001, S_MDEN = 17'h00002, S_MNUM = 17'h00004, S_DST1 = 17'h00008,
        S_DWT1 = 17'h00010, S_FFM  = 17'h00020, S_FFS  = 17'h00040, S_ERR  = 17'h00080,
        S_MP   = 17'h00100, S_MI   = 17'h00200, S_MD   = 17'h00400, S_ML   = 17'h00800,
        S_MLO  = 17'h01000, S_MHI  = 17'h02000, S_DST2 = 17'h04000, S_DWT2 = 17'h08000,
        S_FIN  = 17'h10000
    } t_state;

    t_state r_state;

    // configuration
    logic               r_mode;
    logic signed [31:0] r_gp, r_gi, r_gd, r_slp;
    logic [15:0]        r_tpm;
    logic [7:0]         r_off;

    // per-item and persistent state
    logic [15:0]        r_last_cnt;
    logic signed [16:0] r_last_err, r_err;
    logic signed [31:0] r_sum;
    logic signed [17:0] r_de;
    logic signed [15:0] r_diff, r_tgt, r_speed;
    logic [15:0]        r_el;
    logic [31:0]        r_den;
    logic signed [41:0] r_p, r_i;
    logic [38:0]        r_mag;
    logic               r_dneg;
    logic [57:0]        r_acc;
    logic signed [48:0] r_drv;

    logic               r_ovalid;
    logic [7:0]         r_duty;
    logic               r_da, r_db;
    logic [15:0]        r_ospd;

    logic signed [mspd_pkg::MulW-1:0]  mul_a, mul_b;
    logic signed [mspd_pkg::ProdW-1:0] prod;
    logic                              div_start;
    logic [mspd_pkg::DivNW-1:0]        div_num, quo;
    logic [mspd_pkg::DivDW-1:0]        div_den;
    mspd_pkg::t_div_stat               div_stat;

    mspd_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_prod(prod));

    mspd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_quo(quo), .o_stat(div_stat)
    );

    logic               in_xfer;
    logic [15:0]        diff_mag;
    logic signed [15:0] speed_v;
    logic signed [16:0] err_v;
    logic signed [32:0] sum_x;
    logic [65:0]        m_mag;
    logic signed [41:0] d_v;
    logic signed [48:0] adj;
    logic signed [32:0] drv_q;
    logic signed [9:0]  drv_c;
    logic [15:0]        tpm_eff;

    assign in_xfer  = i_s_tvalid && o_s_tready;
    assign diff_mag = r_diff[15] ? 16'(-r_diff) : r_diff;
    assign tpm_eff  = (r_tpm == 16'd0) ? 16'd1 : r_tpm;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MDEN: begin
                mul_a = {17'b0, tpm_eff};
                mul_b = {17'b0, r_el};
            end
            S_MNUM: begin
                mul_a = {17'b0, diff_mag};
                mul_b = {3'b0, mspd_pkg::NsPerS};
            end
            S_FFM: begin
                mul_a = {r_slp[31], r_slp};
                mul_b = 33'(r_tgt);
            end
            S_MP: begin
                mul_a = {r_gp[31], r_gp};
                mul_b = 33'(r_err);
            end
            S_MI: begin
                mul_a = {r_gi[31], r_gi};
                mul_b = {r_sum[31], r_sum};
            end
            S_MD: begin
                mul_a = {r_gd[31], r_gd};
                mul_b = 33'(r_de);
            end
            S_MLO: begin
                mul_a = {14'b0, r_mag[18:0]};
                mul_b = {13'b0, mspd_pkg::UsPerS};
            end
            S_MHI: begin
                mul_a = {13'b0, r_mag[38:19]};
                mul_b = {13'b0, mspd_pkg::UsPerS};
            end
            default: ;
        endcase
    end

    always_comb begin
        div_start = (r_state == S_DST1) || (r_state == S_DST2);
        if (r_state == S_DST1) begin
            div_num = prod[57:0];
            div_den = r_den;
        end else begin
            div_num = r_acc + {prod[38:0], 19'b0};
            div_den = {16'b0, r_el};
        end
    end

    always_comb begin
        // speed magnitude saturated, sign from the tick difference
        if (r_diff[15]) begin
            speed_v = (quo > 58'd32768) ? -16'sd32768 : 16'(-quo[15:0]);
        end else begin
            speed_v = (quo > 58'd32767) ? 16'sd32767 : quo[15:0];
        end
        err_v = 17'(r_tgt) - 17'(r_speed);
        sum_x = 33'(r_sum) + 33'(r_err);
        m_mag = prod[65] ? 66'(-prod) : prod;
        if (quo > (58'd1 << 40)) d_v = r_dneg ? -(42'sd1 <<< 40) : (42'sd1 <<< 40);
        else                     d_v = r_dneg ? -42'(quo[40:0]) : 42'(quo[40:0]);
        // truncate toward zero on the signed Q32.16 drive
        adj   = r_drv + (r_drv[48] ? 49'sd65535 : 49'sd0);
        drv_q = 33'(adj >>> 16);
        if (drv_q > 33'sd255)       drv_c = 10'sd255;
        else if (drv_q < -33'sd255) drv_c = -10'sd255;
        else                        drv_c = drv_q[9:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_gp   <= '0;
            r_gi   <= '0;
            r_gd   <= '0;
            r_slp  <= '0;
            r_tpm  <= mspd_pkg::TpmRst;
            r_off  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mspd_pkg::REG_MODE: r_mode <= i_cfg_data[0];
                mspd_pkg::REG_GP:   r_gp   <= i_cfg_data;
                mspd_pkg::REG_GI:   r_gi   <= i_cfg_data;
                mspd_pkg::REG_GD:   r_gd   <= i_cfg_data;
                mspd_pkg::REG_TPM:  r_tpm  <= i_cfg_data[15:0];
                mspd_pkg::REG_OFF:  r_off  <= i_cfg_data[7:0];
                mspd_pkg::REG_SLP:  r_slp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_last_cnt <= '0;
            r_last_err <= '0;
            r_sum      <= '0;
        end else begin
            if (r_state == S_FIN && (!r_ovalid || i_m_tready)) r_ovalid <= 1'b1;
            else if (o_m_tvalid && i_m_tready)                 r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_xfer) begin
                    r_diff     <= 16'(i_s_tdata[15:0] - r_last_cnt);
                    r_last_cnt <= i_s_tdata[15:0];
                    r_el       <= (i_s_tdata[31:16] == 16'd0) ? 16'd1 : i_s_tdata[31:16];
                    r_tgt      <= i_s_tdata[47:32];
                    r_state    <= S_MDEN;
                end
                S_MDEN: r_state <= S_MNUM;
                S_MNUM: begin
                    r_den   <= prod[31:0];
                    r_state <= S_DST1;
                end
                S_DST1: r_state <= S_DWT1;
                S_DWT1: if (div_stat.done) begin
                    r_speed <= speed_v;
                    r_state <= r_mode ? S_FFM : S_ERR;
                end
                S_FFM: r_state <= S_FFS;
                S_FFS: begin
                    if (r_tgt > 16'sd0)
                        r_drv <= prod[48:0] + 49'({1'b0, r_off, 16'b0});
                    else if (r_tgt < 16'sd0)
                        r_drv <= prod[48:0] - 49'({1'b0, r_off, 16'b0});
                    else
                        r_drv <= '0;
                    r_state <= S_FIN;
                end
                S_ERR: begin
                    r_err      <= err_v;
                    r_de       <= 18'(err_v) - 18'(r_last_err);
                    r_last_err <= err_v;
                    r_state    <= S_MP;
                end
                S_MP: begin
                    // saturating integral
                    if (sum_x > 33'sd2147483647)       r_sum <= 32'sh7FFFFFFF;
                    else if (sum_x < -33'sd2147483648) r_sum <= 32'sh80000000;
                    else                               r_sum <= sum_x[31:0];
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_p     <= mspd_pkg::sat_term(prod);
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_i     <= mspd_pkg::sat_term(prod);
                    r_state <= S_ML;
                end
                S_ML: begin
                    // magnitudes at or above 2^38 saturate the term anyway
                    r_dneg  <= prod[65];
                    r_mag   <= (m_mag[65:38] != '0) ? (39'd1 << 38) : m_mag[38:0];
                    r_state <= S_MLO;
                end
                S_MLO: r_state <= S_MHI;
                S_MHI: begin
                    r_acc   <= prod[57:0];
                    r_state <= S_DST2;
                end
                S_DST2: r_state <= S_DWT2;
                S_DWT2: if (div_stat.done) begin
                    r_drv   <= 49'(r_p) + 49'(r_i) + 49'(d_v);
                    r_state <= S_FIN;
                end
                S_FIN: if (!r_ovalid || i_m_tready) begin
                    r_ospd   <= r_speed;
                    if (drv_c > 10'sd0) begin
                        r_duty <= drv_c[7:0];
                        r_da   <= 1'b1;
                        r_db   <= 1'b0;
                    end else if (drv_c < 10'sd0) begin
                        r_duty <= 8'(-drv_c);
                        r_da   <= 1'b0;
                        r_db   <= 1'b1;
                    end else begin
                        r_duty <= 8'd0;
                        r_da   <= 1'b1;
                        r_db   <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'b0, r_ospd, r_db, r_da, r_duty};

    a_rdy_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> !o_s_tready)
        else $error("input ready while divider busy");

    a_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[8] || o_m_tdata[9]))
        else $error("no direction pin driven");

    a_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[7:0] == 8'd0) |-> (o_m_tdata[8] && o_m_tdata[9]))
        else $error("zero duty without brake");

    a_div_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !div_stat.busy)
        else $error("divider busy right after input transfer");
endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for motor_speed_pid_drive: directed cases, back-pressure, random runs.
// Expected results come from a behavioral predictor kept in this file; depends on mspd_pkg.
`timescale 1ns / 1ps
module testbench;
    localparam logic [2:0] RegUnused = 3'd7;     // no register behind this index
    localparam longint TermLim = 64'sd1 <<< 40;
    localparam int DrainCycles = 200;            // longer than one PID item

    typedef struct {
        logic [7:0]         duty;
        logic               drive_a;
        logic               drive_b;
        logic signed [15:0] speed;
    } drive_out_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [47:0] i_s_tdata = '0;  // encoder_count, elapsed_us, target_speed
    logic        i_m_tready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;       // duty, drive_a, drive_b, measured_speed, pad

    motor_speed_pid_drive DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of registers and state
    logic   mdl_mode;
    longint mdl_gp, mdl_gi, mdl_gd, mdl_slope;
    longint mdl_tpm, mdl_offset;
    logic [15:0] mdl_last_count;
    longint mdl_last_err, mdl_err_sum;

    drive_out_t drive_q[$];
    int err_count = 0;
    int send_idle = 0;
    int recv_idle = 0;
    logic rx_hold = 1'b0;
    logic [15:0] stim_count = '0;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // trunc(m * 1e6 / e) clipped to the term limit
    function automatic longint rate_term(longint m, longint e);
        logic neg;
        longint unsigned mag, q, r, t, ue;
        neg = m < 0;
        mag = neg ? longint'(-m) : m;
        ue = e;
        q = mag / ue;
        r = mag % ue;
        if (q >= (64'd1 << 21)) t = TermLim;
        else begin
            t = q * 64'd1000000 + (r * 64'd1000000) / ue;
            if (t > TermLim) t = TermLim;
        end
        return neg ? -longint'(t) : longint'(t);
    endfunction

    function automatic drive_out_t predict_drive(logic [47:0] item);
        drive_out_t res;
        logic [15:0] cnt, dlt;
        longint el, tgt, tpm, diff, spd, drv, e, p, i, d;
        cnt = item[15:0];
        el = item[31:16];
        tgt = longint'($signed(item[47:32]));
        if (el == 0) el = 1;
        tpm = (mdl_tpm == 0) ? 1 : mdl_tpm;
        dlt = cnt - mdl_last_count;
        diff = longint'($signed(dlt));
        mdl_last_count = cnt;
        spd = clip((diff * 64'sd1000000000) / (tpm * el), -32768, 32767);
        if (!mdl_mode) begin
            e = tgt - spd;
            mdl_err_sum = clip(mdl_err_sum + e, -64'sd2147483648, 64'sd2147483647);
            p = clip(mdl_gp * e, -TermLim, TermLim);
            i = clip(mdl_gi * mdl_err_sum, -TermLim, TermLim);
            d = rate_term(mdl_gd * (e - mdl_last_err), el);
            mdl_last_err = e;
            drv = p + i + d;
        end else if (tgt > 0) drv = mdl_offset * 65536 + mdl_slope * tgt;
        else if (tgt < 0)     drv = -mdl_offset * 65536 + mdl_slope * tgt;
        else                  drv = 0;
        drv = clip(drv / 65536, -255, 255);
        res.speed = spd[15:0];
        if (drv > 0) begin
            res.duty = drv[7:0]; res.drive_a = 1'b1; res.drive_b = 1'b0;
        end else if (drv < 0) begin
            res.duty = 8'(-drv); res.drive_a = 1'b0; res.drive_b = 1'b1;
        end else begin
            res.duty = '0; res.drive_a = 1'b1; res.drive_b = 1'b1;
        end
        return res;
    endfunction

    task automatic report(string what);
        $display("mismatch @%0t: %s", $realtime, what);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        drive_out_t exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (drive_q.size() == 0) report("result with nothing pending");
            else begin
                exp_r = drive_q.pop_front();
                if (o_m_tdata[7:0] !== exp_r.duty)
                    report($sformatf("duty %0d exp %0d", o_m_tdata[7:0], exp_r.duty));
                if (o_m_tdata[8] !== exp_r.drive_a)
                    report($sformatf("drive_a %b exp %b", o_m_tdata[8], exp_r.drive_a));
                if (o_m_tdata[9] !== exp_r.drive_b)
                    report($sformatf("drive_b %b exp %b", o_m_tdata[9], exp_r.drive_b));
                if (o_m_tdata[25:10] !== exp_r.speed)
                    report($sformatf("speed %0d exp %0d", $signed(o_m_tdata[25:10]),
                                     exp_r.speed));
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold) i_m_tready <= 1'b0;
        else i_m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic hold_receiver(int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mspd_pkg::REG_MODE: mdl_mode = val[0];
            mspd_pkg::REG_GP:   mdl_gp = longint'($signed(val));
            mspd_pkg::REG_GI:   mdl_gi = longint'($signed(val));
            mspd_pkg::REG_GD:   mdl_gd = longint'($signed(val));
            mspd_pkg::REG_TPM:  mdl_tpm = val[15:0];
            mspd_pkg::REG_OFF:  mdl_offset = val[7:0];
            mspd_pkg::REG_SLP:  mdl_slope = longint'($signed(val));
            default: ;
        endcase
    endtask

    // one input transfer; valid stays up unless a gap is drawn
    task automatic send_item(logic [15:0] cnt, logic [15:0] el, logic [15:0] tgt);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {tgt, el, cnt};
        do @(posedge i_clk); while (!o_s_tready);
        drive_q.push_back(predict_drive({tgt, el, cnt}));
        stim_count = cnt;
        if ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(4))
            0: return $urandom_range(0, 1 << 19) - (1 << 18);
            1: return $urandom_range(0, 1 << 13) - (1 << 12);
            2: return $urandom;
            3: return $urandom_range(0, 1 << 23) - (1 << 22);
            default: return '0;
        endcase
    endfunction

    task automatic send_random();
        logic [15:0] cnt, el;
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) cnt = stim_count + 16'($urandom_range(0, 200)) - 16'd100;
        else if (pick < 85) cnt = stim_count + 16'($urandom_range(0, 3000)) - 16'd1500;
        else cnt = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 70) el = 16'($urandom_range(500, 20000));
        else if (pick < 90) el = 16'($urandom);
        else el = 16'($urandom_range(0, 3));
        send_item(cnt, el, 16'($urandom));
    endtask

    task automatic randomize_settings();
        logic [31:0] tpm;
        case ($urandom_range(3))
            0: tpm = 32'd0;
            1: tpm = 32'h0000_FFFF;
            default: tpm = $urandom_range(1, 4000);
        endcase
        write_reg(mspd_pkg::REG_MODE, $urandom_range(1));
        write_reg(mspd_pkg::REG_GP, rand_gain());
        write_reg(mspd_pkg::REG_GI, rand_gain());
        write_reg(mspd_pkg::REG_GD, rand_gain());
        write_reg(mspd_pkg::REG_TPM, tpm);
        write_reg(mspd_pkg::REG_OFF, $urandom_range(255));
        write_reg(mspd_pkg::REG_SLP, rand_gain());
    endtask

    task automatic test_pid_directed();
        write_reg(mspd_pkg::REG_GP, 32'h0002_0000);
        write_reg(mspd_pkg::REG_GI, 32'h0000_0100);
        write_reg(mspd_pkg::REG_GD, 32'h0000_0010);
        send_item(16'd100, 16'd10000, 16'd200);      // forward
        send_item(16'd200, 16'd0, 16'sh8000);        // zero elapsed, speed clips high
        send_item(16'hFFF0, 16'd10000, 16'd0);       // reverse wrap
        send_item(16'h0010, 16'd10000, 16'h7FFF);    // forward wrap
        send_item(16'h0010, 16'hFFFF, -16'sd500);
        drain();
        write_reg(mspd_pkg::REG_GP, 32'h8000_0000);
        write_reg(mspd_pkg::REG_GI, 32'h7FFF_FFFF);
        write_reg(mspd_pkg::REG_GD, 32'h8000_0000);
        write_reg(mspd_pkg::REG_TPM, 32'd0);         // treated as one tick per meter
        send_item(16'h8010, 16'd1, 16'h7FFF);
        send_item(16'h0010, 16'd1, 16'sh8000);
        send_item(16'h0010, 16'd65535, 16'd0);
        drain();
        write_reg(mspd_pkg::REG_GP, '0);
        write_reg(mspd_pkg::REG_GI, '0);
        write_reg(mspd_pkg::REG_GD, '0);
        write_reg(mspd_pkg::REG_TPM, 32'd65535);
        send_item(16'h0020, 16'd1000, 16'd300);      // zero gains: brake
        drain();
    endtask

    task automatic test_ff_directed();
        write_reg(mspd_pkg::REG_MODE, 32'd1);
        write_reg(mspd_pkg::REG_OFF, 32'd255);
        write_reg(mspd_pkg::REG_SLP, 32'h0000_0000);
        write_reg(RegUnused, 32'hFFFF_FFFF);         // must be ignored
        send_item(16'h0040, 16'd1000, 16'd0);        // zero target: brake
        send_item(16'h0050, 16'd1000, 16'd1);
        send_item(16'h0060, 16'd1000, -16'sd1);
        drain();
        write_reg(mspd_pkg::REG_OFF, 32'd10);
        write_reg(mspd_pkg::REG_SLP, 32'h7FFF_FFFF);
        send_item(16'h0070, 16'd1000, 16'h7FFF);
        send_item(16'h0080, 16'd1000, 16'sh8000);
        drain();
        write_reg(mspd_pkg::REG_OFF, 32'd0);
        write_reg(mspd_pkg::REG_SLP, 32'hFFFF_0000); // -1 duty per mm/s
        send_item(16'h0090, 16'd1000, 16'd100);
        send_item(16'h00A0, 16'd1000, -16'sd100);
        send_item(16'h00B0, 16'd1000, 16'd3);
        drain();
        write_reg(mspd_pkg::REG_MODE, 32'd0);
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        write_reg(mspd_pkg::REG_GP, 32'h0001_0000);
        fork
            hold_receiver(800);
            repeat (20) send_random();
        join
        drain();
    endtask

    task automatic test_random(int s_idle, int r_idle, int items);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int n = 0; n < items; n++) begin
            if (n % 60 == 0) begin
                drain();
                randomize_settings();
            end
            send_random();
        end
        drain();
    endtask

    initial begin
        mdl_mode = 1'b0;
        mdl_gp = 0; mdl_gi = 0; mdl_gd = 0; mdl_slope = 0;
        mdl_tpm = mspd_pkg::TpmRst; mdl_offset = 0;
        mdl_last_count = '0; mdl_last_err = 0; mdl_err_sum = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_pid_directed();
        test_ff_directed();
        test_backpressure();
        test_random(32, 69, 460);
        test_random(69, 32, 460);
        test_random(0, 0, 460);
        if (err_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
